[rtl/led_strip_pattern_generator_assert.svh]
// Assertion macros for the LED strip pattern generator RTL.
// Standalone; included by the modules that check their own logic.
`ifndef LED_STRIP_PATTERN_GENERATOR_ASSERT_SVH
`define LED_STRIP_PATTERN_GENERATOR_ASSERT_SVH

// cons must hold in the same cycle as ante
`define LSPG_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define LSPG_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// expr must never hold
`define LSPG_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

[rtl/lspg_pkg.sv]
// Shared types and constants of the LED strip pattern generator.
// No dependencies; imported by the front, queue, back and top level.
package lspg_pkg;

  // width of a pixel position inside a frame job
  localparam int PW = 8;

  localparam logic [23:0] START_COLOUR_RST = 24'h0000FF;
  localparam logic [23:0] COLOUR_BLUE      = 24'h0000FF;
  localparam logic [23:0] COLOUR_GREEN     = 24'h00FF00;
  localparam logic [23:0] COLOUR_RED       = 24'hFF0000;

  typedef enum logic [2:0] {
    MODE_BARS          = 3'd0,
    MODE_WALK          = 3'd1,
    MODE_WIPE          = 3'd2,
    MODE_RAINBOW       = 3'd3,
    MODE_EVEN_RAINBOW  = 3'd4,
    MODE_CHASE         = 3'd5,
    MODE_RAINBOW_CHASE = 3'd6
  } lspg_mode_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_STATS,
    F_MUL,
    F_DIV,
    F_PUSH
  } lspg_fstate_t;

  // one frame worth of render context, handed from front to back
  typedef struct packed {
    lspg_mode_t      mode;
    logic [PW-1:0]   pos;
    logic [1:0]      phase;
    logic [7:0]      hue;
    logic [23:0]     held;
    logic [7:0]      lmin;
    logic [7:0]      llvl;
    logic [7:0]      lmax;
    logic [7:0]      bright;
  } lspg_job_t;

endpackage

[rtl/lspg_queue.sv]
// Two-entry job queue between the frame front end and the pixel back end.
// Uses lspg_pkg and the assertion macros header.
`include "led_strip_pattern_generator_assert.svh"

module lspg_queue import lspg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  lspg_job_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output lspg_job_t pop_data
);

  lspg_job_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_acc;
  logic       pop_acc;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign push_acc   = push_valid && push_ready;
  assign pop_acc    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_acc) wr_ptr <= ~wr_ptr;
      if (pop_acc) rd_ptr <= ~rd_ptr;
      if (push_acc && !pop_acc) count <= count + 2'd1;
      else if (pop_acc && !push_acc) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) slot[wr_ptr] <= push_data;
  end

  `LSPG_NEVER(a_q_count_max, clk, rst, count == 2'd3, "queue count out of range")
  `LSPG_NEXT(a_q_fill, clk, rst, push_acc && !pop_acc, count == $past(count) + 2'd1, "queue fill miscounted")
  `LSPG_NEXT(a_q_drain, clk, rst, pop_acc && !push_acc, count == $past(count) - 2'd1, "queue drain miscounted")

endmodule

[rtl/lspg_front.sv]
// Front end: takes frame words, tracks mode, counters, colour and light
// statistics, divides out the brightness and queues a job. Uses lspg_pkg.
module lspg_front import lspg_pkg::*; #(
  parameter int PIXEL_COUNT = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_tilt,
  input  logic [9:0]  in_ldr,
  input  logic [23:0] in_fresh,
  output logic        job_valid,
  input  logic        job_ready,
  output lspg_job_t   job,
  output logic [23:0] start_colour
);

  localparam int IW = $clog2(PIXEL_COUNT);
  localparam logic [IW-1:0] LAST = IW'(PIXEL_COUNT - 1);

  lspg_fstate_t  state, state_next;
  lspg_mode_t    mode, mode_next;
  logic          prev_tilt;
  logic [IW-1:0] pos;
  logic [1:0]    phase;
  logic [7:0]    hue;
  logic [23:0]   held;
  logic          frame_seen;
  logic [7:0]    level, lmin, lmax;
  logic [17:0]   ldr_prod;
  logic [7:0]    lvl_new;
  logic [15:0]   num;
  logic [14:0]   dsh;
  logic [7:0]    quo;
  logic          den_zero;
  logic [2:0]    step_cnt;
  logic          in_acc;
  logic          div_ge;
  logic [7:0]    q_new;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // level = 255 - sample*254/1024
  assign ldr_prod = {8'b0, in_ldr} * 18'd254;
  assign lvl_new  = 8'd255 - ldr_prod[17:10];

  assign div_ge = (16'(dsh) <= num);
  assign q_new  = {quo[6:0], div_ge};

  always_comb begin
    if (prev_tilt && !in_tilt) begin
      mode_next = (mode == MODE_RAINBOW_CHASE) ? MODE_BARS : lspg_mode_t'(3'(mode + 3'd1));
    end else begin
      mode_next = mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    job_valid  = 1'b0;
    case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = F_STATS;
      end
      F_STATS: state_next = F_MUL;
      F_MUL:   state_next = F_DIV;
      F_DIV: begin
        if (step_cnt == 3'd0) state_next = F_PUSH;
      end
      F_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_colour <= START_COLOUR_RST;
      held         <= START_COLOUR_RST;
      frame_seen   <= 1'b0;
      mode         <= MODE_BARS;
      prev_tilt    <= 1'b0;
      pos          <= '0;
      phase        <= 2'd0;
      hue          <= 8'd0;
      level        <= 8'd0;
      lmin         <= 8'd0;
      lmax         <= 8'd0;
    end else begin
      if (cfg_valid) begin
        start_colour <= cfg_data;
        if (!frame_seen) held <= cfg_data;
      end
      if (in_acc) begin
        frame_seen <= 1'b1;
        prev_tilt  <= in_tilt;
        mode       <= mode_next;
        pos        <= (pos == LAST) ? '0 : pos + IW'(1);
        phase      <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
        hue        <= hue + 8'd1;
        if (pos == LAST) held <= in_fresh;
        level      <= lvl_new;
      end
      if (state == F_STATS) begin
        if (level < lmin) lmin <= level;
        if (level > lmax) lmax <= level;
      end
    end
  end

  // render context uses last frame's light figures; brightness the new ones
  always_ff @(posedge clk) begin
    if (in_acc) begin
      job.mode  <= mode_next;
      job.pos   <= PW'(pos);
      job.phase <= phase;
      job.hue   <= hue;
      job.held  <= held;
      job.lmin  <= lmin;
      job.llvl  <= level;
      job.lmax  <= lmax;
    end
    case (state)
      F_MUL: begin
        num      <= 16'(level - lmin) * 16'd254;
        dsh      <= {lmax - lmin, 7'b0};
        den_zero <= (lmax == lmin);
        quo      <= 8'd0;
        step_cnt <= 3'd7;
      end
      F_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (div_ge) num <= num - 16'(dsh);
        quo      <= q_new;
        dsh      <= dsh >> 1;
        step_cnt <= step_cnt - 3'd1;
        if (step_cnt == 3'd0) begin
          if (den_zero || q_new == 8'd255) job.bright <= 8'd255;
          else job.bright <= q_new + 8'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/lspg_back.sv]
// Back end: renders one pixel per cycle, while the output is not stalled, from a queued job
// into the frame buffer and the output register. Uses lspg_pkg and the assertion macros.
`include "led_strip_pattern_generator_assert.svh"

module lspg_back import lspg_pkg::*; #(
  parameter int PIXEL_COUNT = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  lspg_job_t   job_in,
  input  logic [23:0] start_colour,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_index,
  output logic [23:0] out_colour,
  output logic [7:0]  out_bright,
  output logic [2:0]  out_mode,
  output logic        out_last
);

  localparam int IW  = $clog2(PIXEL_COUNT);
  localparam int IW1 = IW + 1;
  localparam logic [IW-1:0] LAST     = IW'(PIXEL_COUNT - 1);
  localparam logic [3:0]    LAST_TAG = 4'((PIXEL_COUNT - 1) % 16);
  localparam logic [8:0]    STEP     = 9'(255 / PIXEL_COUNT);
  localparam logic [7:0]    EVEN_INC = 8'(256 / PIXEL_COUNT);
  localparam logic [IW:0]   EVEN_REM = IW1'(256 % PIXEL_COUNT);
  localparam logic [IW:0]   COUNT_W  = IW1'(PIXEL_COUNT);

  function automatic logic [23:0] wheel(input logic [7:0] wpos);
    logic [7:0] p;
    logic [7:0] t;
    p = 8'd255 - wpos;
    if (p < 8'd85) begin
      t = p * 8'd3;
      wheel = {8'd255 - t, 8'd0, t};
    end else if (p < 8'd170) begin
      t = (p - 8'd85) * 8'd3;
      wheel = {8'd0, t, 8'd255 - t};
    end else begin
      t = (p - 8'd170) * 8'd3;
      wheel = {t, 8'd255 - t, 8'd0};
    end
  endfunction

  lspg_job_t     cur;
  logic          busy;
  logic          buf_filled;
  logic [IW-1:0] cnt;
  logic [7:0]    ev_q;
  logic [IW-1:0] ev_r;
  logic [1:0]    m3;
  logic          s1_valid;
  logic [IW-1:0] s1_idx;
  logic [7:0]    s1_ev;
  logic [1:0]    s1_m3;
  logic          s1_first;
  logic [23:0]   mem_q;
  logic [23:0]   mem [PIXEL_COUNT];

  logic          out_free, adv, issue, load;
  logic [IW:0]   ev_rs;
  logic [7:0]    ev_q_next;
  logic [IW-1:0] ev_r_next;

  logic [PW-1:0] idx8;
  logic [23:0]   old;
  logic          hit_pos;
  logic [8:0]    v, v_hi;
  logic [23:0]   bars;
  logic [8:0]    sum9;
  logic [7:0]    rb_pos, rc_pos, ev_pos;
  logic [2:0]    ph_sum;
  logic          chase_hit;
  logic [23:0]   pix;

  assign out_free  = !out_valid || out_ready;
  assign adv       = s1_valid && out_free;
  assign issue     = busy && (!s1_valid || adv);
  assign job_ready = !busy && !s1_valid;
  assign load      = job_valid && job_ready;

  // running i*256/PIXEL_COUNT as quotient and remainder
  assign ev_rs = {1'b0, ev_r} + EVEN_REM;
  always_comb begin
    if (ev_rs >= COUNT_W) begin
      ev_r_next = IW'(ev_rs - COUNT_W);
      ev_q_next = ev_q + EVEN_INC + 8'd1;
    end else begin
      ev_r_next = ev_rs[IW-1:0];
      ev_q_next = ev_q + EVEN_INC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      buf_filled <= 1'b0;
      cnt        <= '0;
      ev_q       <= 8'd0;
      ev_r       <= '0;
      m3         <= 2'd0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        cnt  <= '0;
        ev_q <= 8'd0;
        ev_r <= '0;
        m3   <= 2'd0;
      end else if (issue) begin
        if (cnt == LAST) begin
          busy       <= 1'b0;
          buf_filled <= 1'b1;
          cnt        <= '0;
        end else begin
          cnt <= cnt + IW'(1);
        end
        ev_q <= ev_q_next;
        ev_r <= ev_r_next;
        m3   <= (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
      end
      if (issue) s1_valid <= 1'b1;
      else if (adv) s1_valid <= 1'b0;
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // frame buffer: read one ahead, write back the rendered pixel
  always_ff @(posedge clk) begin
    if (adv) mem[s1_idx] <= pix;
    if (issue) mem_q <= mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (load) cur <= job_in;
    if (issue) begin
      s1_idx   <= cnt;
      s1_ev    <= ev_q;
      s1_m3    <= m3;
      s1_first <= !buf_filled;
    end
    if (adv) begin
      out_index  <= idx8[3:0];
      out_colour <= pix;
      out_bright <= cur.bright;
      out_mode   <= cur.mode;
      out_last   <= (s1_idx == LAST);
    end
  end

  always_comb begin
    idx8 = PW'(s1_idx);
    // before the first frame is written the buffer holds its reset image
    if (s1_first) old = (s1_idx == '0) ? start_colour : 24'd0;
    else old = mem_q;
    hit_pos = (idx8 == cur.pos);

    v    = STEP * {1'b0, idx8};
    v_hi = v + STEP;
    if ({1'b0, cur.lmin} >= v) bars = COLOUR_BLUE;
    else if ({1'b0, cur.llvl} > v && {1'b0, cur.llvl} < v_hi) bars = COLOUR_GREEN;
    else if ({1'b0, cur.lmax} <= v) bars = COLOUR_RED;
    else bars = 24'd0;

    sum9   = {1'b0, idx8} + {1'b0, cur.hue};
    rb_pos = sum9[7:0];
    rc_pos = (sum9 >= 9'd255) ? 8'(sum9 - 9'd255) : sum9[7:0];
    ev_pos = 8'(s1_ev + cur.hue);

    ph_sum    = {1'b0, s1_m3} + {1'b0, cur.phase};
    chase_hit = (ph_sum == 3'd0) || (ph_sum == 3'd3);

    case (cur.mode)
      MODE_BARS:          pix = bars;
      MODE_WALK:          pix = hit_pos ? cur.held : 24'd0;
      MODE_WIPE: begin
        if (hit_pos) pix = cur.held;
        else if (cur.pos == '0) pix = 24'd0;
        else pix = old;
      end
      MODE_RAINBOW:       pix = wheel(rb_pos);
      MODE_EVEN_RAINBOW:  pix = wheel(ev_pos);
      MODE_CHASE:         pix = chase_hit ? cur.held : 24'd0;
      MODE_RAINBOW_CHASE: pix = chase_hit ? wheel(rc_pos) : 24'd0;
      default:            pix = old;
    endcase
  end

  `LSPG_NEVER(a_bk_addr, clk, rst, adv && (s1_idx > LAST), "pixel beyond frame buffer")
  `LSPG_IMPLY(a_bk_last, clk, rst, out_valid && out_last, out_index == LAST_TAG, "last flag on wrong pixel")
  `LSPG_NEXT(a_bk_end, clk, rst, issue && (cnt == LAST), !busy, "frame issue did not stop")

endmodule

[rtl/led_strip_pattern_generator.sv]
// Channel   | dir | handshake                    | word
// cfg       | in  | cfg_valid / cfg_ready        | cfg_data = start colour
// s_axis    | in  | s_axis_tvalid / tready       | tilt, light sample, fresh colour
// m_axis    | out | m_axis_tvalid / tready       | index, colour, brightness, mode; tlast
//
// A frame word passes through the front end in order: stats, multiply, 8-step divide, push;
// the back end then renders one pixel per cycle through the buffer while the output is not stalled;
// it takes a new job only once the last pixel of the previous one has left its first stage.
// Sync reset; no clearing pass, the buffer reads its reset image until first written.
// Output stalls hold the back end; the two-entry job queue lets the front run ahead.
// Depends on lspg_pkg, lspg_front, lspg_queue, lspg_back.
module led_strip_pattern_generator import lspg_pkg::*; #(
  parameter int PIXEL_COUNT = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [0] tilt_level, [10:1] ldr_sample, [34:11] fresh_colour
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] pixel_index, [27:4] pixel_colour,
                                      // [35:28] frame_brightness, [38:36] current_mode
  output logic        m_axis_tlast
);

  lspg_job_t   fr_job, q_job;
  logic        fr_valid, fr_ready;
  logic        q_valid, q_ready;
  logic [23:0] start_colour;
  logic [3:0]  o_index;
  logic [23:0] o_colour;
  logic [7:0]  o_bright;
  logic [2:0]  o_mode;

  lspg_front #(.PIXEL_COUNT(PIXEL_COUNT)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_tilt      (s_axis_tdata[0]),
    .in_ldr       (s_axis_tdata[10:1]),
    .in_fresh     (s_axis_tdata[34:11]),
    .job_valid    (fr_valid),
    .job_ready    (fr_ready),
    .job          (fr_job),
    .start_colour (start_colour)
  );

  lspg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  lspg_back #(.PIXEL_COUNT(PIXEL_COUNT)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_valid),
    .job_ready    (q_ready),
    .job_in       (q_job),
    .start_colour (start_colour),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_index    (o_index),
    .out_colour   (o_colour),
    .out_bright   (o_bright),
    .out_mode     (o_mode),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, o_mode, o_bright, o_colour, o_index};

endmodule

[test/testbench.sv]
// Self-checking bench for led_strip_pattern_generator: frames in, pixel words out.
// Needs lspg_pkg and the RTL; an internal frame predictor supplies the expected words.
`timescale 1ns / 100ps

module testbench;
  import lspg_pkg::*;

  localparam int PIXELS     = 13;
  localparam int MODE_COUNT = 7;

  typedef struct {
    logic [3:0]  index;
    logic [23:0] colour;
    logic [7:0]  bright;
    lspg_mode_t  mode;
    logic        last;
  } pixel_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [0] tilt, [10:1] ldr sample, [34:11] fresh colour
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [3:0] index, [27:4] colour, [35:28] brightness,
                                    // [38:36] mode
  logic        m_axis_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int words_seen    = 0;

  pixel_word_t expected_pixels[$];

  // predictor state
  logic [23:0] pix_buf [PIXELS];
  lspg_mode_t  anim_mode  = MODE_BARS;
  logic        prev_tilt  = 1'b0;
  logic [3:0]  pos        = '0;
  logic [1:0]  phase      = '0;
  logic [7:0]  hue        = '0;
  logic [23:0] start_col  = START_COLOUR_RST;
  logic [23:0] held       = START_COLOUR_RST;
  logic [7:0]  lvl        = '0;
  logic [7:0]  lmin       = '0;
  logic [7:0]  lmax       = '0;
  logic        frame_seen = 1'b0;

  led_strip_pattern_generator #(.PIXEL_COUNT(PIXELS)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  function automatic logic [23:0] pixel_wheel(input logic [7:0] at);
    int p;
    p = 255 - int'(at);
    if (p < 85) return {8'(255 - p * 3), 8'd0, 8'(p * 3)};
    if (p < 170) begin
      p -= 85;
      return {8'd0, 8'(p * 3), 8'(255 - p * 3)};
    end
    p -= 170;
    return {8'(p * 3), 8'(255 - p * 3), 8'd0};
  endfunction

  // renders one frame, updates light stats and counters, queues 13 pixel words
  function automatic void predict_frame(input logic tilt, input logic [9:0] ldr,
                                        input logic [23:0] fresh);
    int step;
    int v;
    int brt;
    pixel_word_t w;
    step = 255 / PIXELS;
    frame_seen = 1'b1;
    if (!tilt && prev_tilt) anim_mode = lspg_mode_t'((int'(anim_mode) + 1) % MODE_COUNT);
    prev_tilt = tilt;

    case (anim_mode)
      MODE_BARS: begin
        for (int i = 0; i < PIXELS; i++) begin
          v = step * i;
          pix_buf[i] = '0;
          if (int'(lmin) >= v) pix_buf[i] = COLOUR_BLUE;
          else if (int'(lvl) > v && int'(lvl) < v + step) pix_buf[i] = COLOUR_GREEN;
          else if (int'(lmax) <= v) pix_buf[i] = COLOUR_RED;
        end
      end
      MODE_WALK: begin
        pix_buf = '{default: '0};
        pix_buf[pos] = held;
      end
      MODE_WIPE: begin
        if (pos == 0) pix_buf = '{default: '0};
        pix_buf[pos] = held;
      end
      MODE_RAINBOW: begin
        for (int i = 0; i < PIXELS; i++) pix_buf[i] = pixel_wheel(8'((i + hue) & 255));
      end
      MODE_EVEN_RAINBOW: begin
        for (int i = 0; i < PIXELS; i++)
          pix_buf[i] = pixel_wheel(8'((i * 256 / PIXELS + hue) & 255));
      end
      MODE_CHASE: begin
        pix_buf = '{default: '0};
        for (int i = 0; i < PIXELS; i++)
          if ((i + phase) % 3 == 0) pix_buf[i] = held;
      end
      MODE_RAINBOW_CHASE: begin
        pix_buf = '{default: '0};
        for (int i = 0; i < PIXELS; i++)
          if ((i + phase) % 3 == 0) pix_buf[i] = pixel_wheel(8'((i + hue) % 255));
      end
      default: ;
    endcase

    lvl = 8'(255 - (int'(ldr) * 254) / 1024);
    if (lvl < lmin) lmin = lvl;
    if (lvl > lmax) lmax = lvl;
    if (lmax > lmin) brt = (int'(lvl) - int'(lmin)) * 254 / (int'(lmax) - int'(lmin)) + 1;
    else brt = 255;
    if (brt > 255) brt = 255;

    for (int i = 0; i < PIXELS; i++) begin
      w.index  = 4'(i);
      w.colour = pix_buf[i];
      w.bright = 8'(brt);
      w.mode   = anim_mode;
      w.last   = (i == PIXELS - 1);
      expected_pixels.push_back(w);
    end

    pos   = (pos == PIXELS - 1) ? 4'd0 : pos + 4'd1;
    phase = (phase == 2) ? 2'd0 : phase + 2'd1;
    hue   = hue + 8'd1;
    if (pos == 0) held = fresh;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got %0h expected %0h", words_seen, name, got,
                                want));
  endtask

  // input and config monitors feed the predictor; output words are checked here
  always @(posedge clk) begin
    pixel_word_t w;
    if (!rst && cfg_valid && cfg_ready) begin
      start_col = cfg_data;
      if (!frame_seen) begin
        held = start_col;
        pix_buf[0] = start_col;
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready)
      predict_frame(s_axis_tdata[0], s_axis_tdata[10:1], s_axis_tdata[34:11]);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel word %h", m_axis_tdata));
      end else begin
        w = expected_pixels.pop_front();
        check_field("index", m_axis_tdata[3:0], w.index);
        check_field("colour", m_axis_tdata[27:4], w.colour);
        check_field("brightness", m_axis_tdata[35:28], w.bright);
        check_field("mode", m_axis_tdata[38:36], w.mode);
        check_field("tlast", m_axis_tlast, w.last);
      end
      words_seen++;
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_frame(input logic tilt, input logic [9:0] ldr,
                            input logic [23:0] fresh);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= {5'd0, fresh, ldr, tilt};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_start_colour(input logic [23:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // block is idle once the last word is out and the front end has settled
  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    // let the monitor queue the frame accepted at this edge
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIXELS + 16) @(posedge clk);
  endtask

  // before any frame the write also loads the held colour and buffer entry 0
  task automatic test_start_colour_before_first_frame();
    write_start_colour(24'h000000);
    write_start_colour(24'hFFFFFF);
  endtask

  // falling tilt edges on every other frame step through all modes and wrap to bars
  task automatic test_mode_walk();
    logic [9:0]  ldr;
    logic [23:0] fresh;
    for (int k = 0; k < 2 * MODE_COUNT; k++) begin
      ldr   = (k == 0) ? 10'd0 : (k == 1) ? 10'd1023 : 10'($urandom_range(0, 1023));
      fresh = (k % 3 == 0) ? 24'h000000 : (k % 3 == 1) ? 24'hFFFFFF : 24'($urandom);
      send_frame(k % 2 == 0, ldr, fresh);
    end
    // tilt held high: no edge, then one edge
    send_frame(1'b1, 10'd1023, 24'hFFFFFF);
    send_frame(1'b1, 10'd0, 24'h000000);
    send_frame(1'b0, 10'd600, 24'($urandom));
    drain_frames();
  endtask

  task automatic test_random_frames(input int count, input int send_idle,
                                    input int recv_idle);
    logic [9:0] ldr;
    int pick;
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      ldr  = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 : 10'($urandom_range(0, 1023));
      send_frame($urandom_range(0, 2) == 0, ldr, 24'($urandom));
    end
    drain_frames();
  endtask

  initial begin
    int waited;
    pix_buf = '{default: '0};
    pix_buf[0] = START_COLOUR_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 64;
    test_start_colour_before_first_frame();
    test_mode_walk();
    // after the first frame the register is stored only
    write_start_colour(24'hFFFFFF);
    test_random_frames(34, 24, 64);
    write_start_colour(24'h000000);
    test_random_frames(33, 64, 24);
    write_start_colour(24'($urandom));
    test_random_frames(33, 0, 0);

    waited = 0;
    while (expected_pixels.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixel words never arrived", expected_pixels.size()));

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
